### design/tec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tec_pkg
// Types, register codes and arithmetic helpers for the texture combiner.
// ----------------------------------------------------------------------------
package tec_pkg;

   localparam int ARGB_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int Q_W       = 20;   // signed Q16 working width
   localparam int P_W       = 40;   // product / sum width
   localparam int ONE_Q16   = 65536;
   localparam int HALF_Q16  = 32768;

   typedef enum logic [2:0] {
      MODE_REPLACE  = 3'd0,
      MODE_MODULATE = 3'd1,
      MODE_DECAL    = 3'd2,
      MODE_BLEND    = 3'd3,
      MODE_ADD      = 3'd4,
      MODE_COMBINE  = 3'd5,
      MODE_PASS     = 3'd6,
      MODE_PASS_ALT = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      FN_REPLACE   = 3'd0,
      FN_MODULATE  = 3'd1,
      FN_ADD       = 3'd2,
      FN_ADD_SIGN  = 3'd3,
      FN_INTERP    = 3'd4,
      FN_SUBTRACT  = 3'd5,
      FN_DOT3_RGB  = 3'd6,
      FN_DOT3_RGBA = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      REG_ENV_MODE   = 3'd0,
      REG_RGB_FUNC   = 3'd1,
      REG_ALPHA_FUNC = 3'd2,
      REG_SOURCES    = 3'd3,
      REG_OPERANDS   = 3'd4,
      REG_CONST      = 3'd5,
      REG_RGB_GAIN   = 3'd6,
      REG_ALPHA_GAIN = 3'd7
   } reg_type;

   typedef struct packed {
      logic [2:0]  env_mode;
      logic [2:0]  rgb_func;
      logic [2:0]  alpha_func;
      logic [11:0] sources;
      logic [8:0]  operands;
      logic [31:0] const_color;
      logic [1:0]  rgb_gain;
      logic [1:0]  alpha_gain;
   } cfg_type;

   // byte -> Q16: round(b*65536/255) == b*257 + (b>>7)
   function automatic logic signed [Q_W-1:0] to_q(input logic [7:0] b);
      logic [16:0] v;
      v = 17'({9'd0, b} * 17'd257) + 17'(b[7]);
      return Q_W'(signed'({1'b0, v}));
   endfunction

   // round half away from zero by 16 bits
   function automatic logic signed [P_W-1:0] rnd16(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] m;
      logic signed [P_W-1:0] r;
      m = v[P_W-1] ? -v : v;
      r = (m + P_W'(HALF_Q16)) >>> 16;
      return v[P_W-1] ? -r : r;
   endfunction

   function automatic logic signed [P_W-1:0] rnd14(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] m;
      logic signed [P_W-1:0] r;
      m = v[P_W-1] ? -v : v;
      r = (m + P_W'(8192)) >>> 14;
      return v[P_W-1] ? -r : r;
   endfunction

   // clamp to [0, 1.0] and pack to a byte
   function automatic logic [7:0] to_byte(input logic signed [P_W-1:0] q);
      logic [16:0] c;
      logic [25:0] p;
      if (q < 0)                    c = 17'd0;
      else if (q > P_W'(ONE_Q16))   c = 17'd65536;
      else                          c = q[16:0];
      p = 26'(c) * 26'd255 + 26'd32768;
      return p[23:16];
   endfunction

endpackage : tec_pkg
`default_nettype wire

### design/tec_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tec_stream_if
// Valid/ready channel with a parameterized payload.
// ----------------------------------------------------------------------------
interface tec_stream_if #(
   parameter int W = 32
);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : tec_stream_if
`default_nettype wire

### design/tec_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tec_datapath
// Three-stage combine datapath with a shared advance enable.
// s1: convert + argument selection, s2: products, s3: round/scale/pack.
// ----------------------------------------------------------------------------
module tec_datapath (
   input  wire logic                  clock,
   input  wire logic                  adv,
   input  wire tec_pkg::cfg_type      cfg,
   input  wire logic [31:0]           texel,
   input  wire logic [31:0]           primary,
   input  wire logic [31:0]           previous,
   output logic [31:0]                result
);
   import tec_pkg::*;

   typedef logic signed [Q_W-1:0] q_type;
   typedef logic signed [P_W-1:0] p_type;

   // ---- stage 1: convert and select
   q_type x_in [4], y_in [4], w_in [4], z_in [4];  // per channel: x*w + y*z
   logic  add_in [4];          // pass x+y sums (no product)
   logic  dot_in;
   logic  dota_in;             // dot product also drives alpha
   logic  byp_in;
   logic [31:0] byp_val_in;
   logic [1:0]  sc_in [4];

   q_type x_ff [4], y_ff [4], w_ff [4], z_ff [4];
   logic  add_ff [4];
   logic  dot_ff, dota_ff, byp_ff;
   logic [31:0] byp_val_ff;
   logic [1:0]  sc_ff [4];

   function automatic q_type chan(input logic [31:0] c, input int i);
      case (i)
         0: return to_q(c[23:16]);
         1: return to_q(c[15:8]);
         2: return to_q(c[7:0]);
         default: return to_q(c[31:24]);
      endcase
   endfunction

   always_comb begin
      q_type tx [4], pr [4], pv [4], cs [4];
      q_type ra [3][3];
      q_type aa [3];
      q_type s [4];
      q_type sa [4];
      logic [1:0] sel, op;
      logic [2:0] rf, af;
      for (int i = 0; i < 4; i++) begin
         tx[i] = chan(texel, i);
         pr[i] = chan(primary, i);
         pv[i] = chan(previous, i);
         cs[i] = chan(cfg.const_color, i);
      end
      for (int k = 0; k < 3; k++) begin
         sel = cfg.sources[2*k +: 2];
         for (int i = 0; i < 4; i++)
            case (sel)
               2'd0:    s[i] = tx[i];
               2'd1:    s[i] = cs[i];
               2'd2:    s[i] = pr[i];
               default: s[i] = pv[i];
            endcase
         sel = cfg.sources[6+2*k +: 2];
         for (int i = 0; i < 4; i++)
            case (sel)
               2'd0:    sa[i] = tx[i];
               2'd1:    sa[i] = cs[i];
               2'd2:    sa[i] = pr[i];
               default: sa[i] = pv[i];
            endcase
         op = cfg.operands[2*k +: 2];
         for (int i = 0; i < 3; i++)
            case (op)
               2'd0:    ra[k][i] = s[i];
               2'd1:    ra[k][i] = q_type'(ONE_Q16) - s[i];
               2'd2:    ra[k][i] = s[3];
               default: ra[k][i] = q_type'(ONE_Q16) - s[3];
            endcase
         aa[k] = cfg.operands[6+k] ? q_type'(ONE_Q16) - sa[3] : sa[3];
      end
      rf = cfg.rgb_func;
      af = cfg.alpha_func;
      dot_in = 1'b0;
      dota_in = 1'b0;
      byp_in = 1'b0;
      byp_val_in = previous;
      for (int i = 0; i < 4; i++) begin
         x_in[i] = pv[i]; y_in[i] = '0; w_in[i] = q_type'(ONE_Q16); z_in[i] = '0;
         add_in[i] = 1'b0;
         sc_in[i] = 2'd0;
      end
      case (mode_type'(cfg.env_mode))
         MODE_REPLACE: begin
            for (int i = 0; i < 4; i++) x_in[i] = tx[i];
         end
         MODE_MODULATE: begin
            for (int i = 0; i < 4; i++) w_in[i] = tx[i];
         end
         MODE_DECAL: begin
            for (int i = 0; i < 3; i++) begin
               x_in[i] = tx[i]; w_in[i] = tx[3];
               y_in[i] = pv[i]; z_in[i] = q_type'(ONE_Q16) - tx[3];
            end
         end
         MODE_BLEND: begin
            for (int i = 0; i < 3; i++) begin
               x_in[i] = cs[i]; w_in[i] = tx[i];
               y_in[i] = pv[i]; z_in[i] = q_type'(ONE_Q16) - tx[i];
            end
            w_in[3] = tx[3];
         end
         MODE_ADD: begin
            for (int i = 0; i < 3; i++) begin
               y_in[i] = tx[i]; add_in[i] = 1'b1;
            end
            w_in[3] = tx[3];
         end
         MODE_COMBINE: begin
            for (int i = 0; i < 4; i++) begin
               sc_in[i] = (i == 3) ? cfg.alpha_gain : cfg.rgb_gain;
               if (sc_in[i] == 2'd3) sc_in[i] = 2'd2;
            end
            if (rf == FN_DOT3_RGB || rf == FN_DOT3_RGBA) begin
               dot_in = 1'b1;
               dota_in = (rf == FN_DOT3_RGBA);
               for (int i = 0; i < 3; i++) begin
                  x_in[i] = ra[0][i] - q_type'(HALF_Q16);
                  w_in[i] = ra[1][i] - q_type'(HALF_Q16);
               end
            end
            for (int i = 0; i < 4; i++) begin
               logic [2:0] f;
               q_type a0, a1, a2;
               f  = (i == 3) ? af : rf;
               a0 = (i == 3) ? aa[0] : ra[0][i < 3 ? i : 0];
               a1 = (i == 3) ? aa[1] : ra[1][i < 3 ? i : 0];
               a2 = (i == 3) ? aa[2] : ra[2][i < 3 ? i : 0];
               if (!(i < 3 && dot_in) && !(i == 3 && rf == FN_DOT3_RGBA)) begin
                  w_in[i] = q_type'(ONE_Q16);
                  case (func_type'(f))
                     FN_REPLACE:  x_in[i] = a0;
                     FN_MODULATE: begin x_in[i] = a0; w_in[i] = a1; end
                     FN_ADD:      begin x_in[i] = a0; y_in[i] = a1; add_in[i] = 1'b1; end
                     FN_ADD_SIGN: begin
                        x_in[i] = a0;
                        y_in[i] = a1 - q_type'(HALF_Q16);
                        add_in[i] = 1'b1;
                     end
                     FN_INTERP: begin
                        x_in[i] = a0; w_in[i] = a2;
                        y_in[i] = a1; z_in[i] = q_type'(ONE_Q16) - a2;
                     end
                     FN_SUBTRACT: begin
                        x_in[i] = a0; y_in[i] = -a1; add_in[i] = 1'b1;
                     end
                     default: begin x_in[i] = '0; end
                  endcase
               end
            end
         end
         default: byp_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            x_ff[i] <= x_in[i]; y_ff[i] <= y_in[i];
            w_ff[i] <= w_in[i]; z_ff[i] <= z_in[i];
            add_ff[i] <= add_in[i]; sc_ff[i] <= sc_in[i];
         end
         dot_ff <= dot_in; dota_ff <= dota_in;
         byp_ff <= byp_in; byp_val_ff <= byp_val_in;
      end
   end

   // ---- stage 2: products
   p_type pa_in [4], pb_in [4];
   p_type pa_ff [4], pb_ff [4];
   logic  add2_ff [4];
   logic  dot2_ff, byp2_ff;
   logic [31:0] byp_val2_ff;
   logic [1:0]  sc2_ff [4];
   logic  dota2_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pa_in[i] = add_ff[i] ? p_type'(x_ff[i]) : p_type'(x_ff[i]) * p_type'(w_ff[i]);
         pb_in[i] = add_ff[i] ? p_type'(y_ff[i]) : p_type'(y_ff[i]) * p_type'(z_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            pa_ff[i] <= pa_in[i]; pb_ff[i] <= pb_in[i];
            add2_ff[i] <= add_ff[i]; sc2_ff[i] <= sc_ff[i];
         end
         dot2_ff <= dot_ff; byp2_ff <= byp_ff; byp_val2_ff <= byp_val_ff;
         dota2_ff <= dota_ff;
      end
   end

   // ---- stage 3: round, scale, pack
   logic [31:0] res_in;
   logic [31:0] res_ff;
   logic        dot_alpha;

   assign dot_alpha = dota2_ff;

   always_comb begin
      p_type v [4];
      p_type dsum;
      p_type dv;
      dsum = pa_ff[0] + pa_ff[1] + pa_ff[2];
      dv = rnd14(dsum);
      for (int i = 0; i < 4; i++) begin
         if (add2_ff[i]) v[i] = pa_ff[i] + pb_ff[i];
         else            v[i] = rnd16(pa_ff[i] + pb_ff[i]);
         if (dot2_ff && i < 3) v[i] = dv;
         v[i] = v[i] <<< sc2_ff[i];
      end
      if (dot_alpha) v[3] = dv <<< sc2_ff[3];
      res_in = {to_byte(v[3]), to_byte(v[0]), to_byte(v[1]), to_byte(v[2])};
      if (byp2_ff) res_in = byp_val2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) res_ff <= res_in;
   end

   assign result = res_ff;

endmodule : tec_datapath
`default_nettype wire

### design/texture_environment_combiner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// texture_environment_combiner_top
// One fixed-function texture environment stage, ARGB8888 in and out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | beat
//  req     | in  | texel_argb, primary_argb, previous_argb   | valid & ready
//  rsp     | out | result_argb                               | valid & ready
//  csr     | in  | index, 32-bit data                        | csr_write_enable
//
//  One beat per clock unless stalled; beats pass through the select, multiply
//  and round/pack register stages. All stages advance together, so a stalled
//  rsp holds the whole pipe; req_ready is high whenever the output stage is
//  empty or draining. Reset clears valid bits and registers to defaults.
// ----------------------------------------------------------------------------
module texture_environment_combiner_top (
   input  wire logic        clock,
   input  wire logic        reset,
   tec_stream_if.sink       req,
   tec_stream_if.source     rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [tec_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tec_pkg::ARGB_W-1:0]    csr_write_data
);
   import tec_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] vld_ff;
   logic       adv;

   // Pipe advances unless the result stage is full and not taken.
   assign adv       = !vld_ff[2] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.env_mode    <= MODE_MODULATE;
         cfg_ff.rgb_func    <= FN_MODULATE;
         cfg_ff.alpha_func  <= FN_MODULATE;
         cfg_ff.sources     <= 12'd1820;
         cfg_ff.operands    <= 9'd32;
         cfg_ff.const_color <= '0;
         cfg_ff.rgb_gain    <= '0;
         cfg_ff.alpha_gain  <= '0;
      end else if (csr_write_enable) begin
         case (reg_type'(csr_index))
            REG_ENV_MODE:    cfg_ff.env_mode    <= csr_write_data[2:0];
            REG_RGB_FUNC:    cfg_ff.rgb_func    <= csr_write_data[2:0];
            REG_ALPHA_FUNC:  cfg_ff.alpha_func  <= csr_write_data[2:0];
            REG_SOURCES:     cfg_ff.sources     <= csr_write_data[11:0];
            REG_OPERANDS:    cfg_ff.operands    <= csr_write_data[8:0];
            REG_CONST:       cfg_ff.const_color <= csr_write_data;
            REG_RGB_GAIN:    cfg_ff.rgb_gain    <= csr_write_data[1:0];
            REG_ALPHA_GAIN:  cfg_ff.alpha_gain  <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   tec_datapath u_dp (
      .clock    (clock),
      .adv      (adv),
      .cfg      (cfg_ff),
      .texel    (req.data[95:64]),
      .primary  (req.data[63:32]),
      .previous (req.data[31:0]),
      .result   (rsp.data)
   );

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed under stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted beat lost");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe moved while stalled");
`endif

endmodule : texture_environment_combiner_top
`default_nettype wire
